// ----- hw/rtl/afu_pkg.sv -----
// ----------------------------------------------------------------------------
// afu_pkg
// Shared types, register codes and elaboration-time constant helpers for the
// activation function unit.
// ----------------------------------------------------------------------------
package afu_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;
	localparam int DIV_STEPS      = 32;
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVATION_KIND = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DERIVATIVE_MODE = 1'b1;

	typedef enum logic [2:0] {
		KIND_IDENTITY = 3'd0,
		KIND_BINARY   = 3'd1,
		KIND_SIGMOID  = 3'd2,
		KIND_TANH     = 3'd3,
		KIND_RELU     = 3'd4,
		KIND_SOFTPLUS = 3'd5
	} kind_t;

	typedef struct packed {
		logic  valid;
		logic  neg;
		kind_t kind;
		logic  deriv;
	} ctrl_t;

	// e^-(2^e) in unsigned q32
	function automatic logic [31:0] exp_q32(input int e);
		real    arg;
		real    v;
		longint tmp;
		begin
			arg = 2.0 ** e;
			if (arg >= 32.0) return 32'd0;
			v = $exp(-arg) * 4294967296.0;
			if (v >= 4294967295.0) return 32'hFFFF_FFFF;
			tmp = longint'(v);
			return tmp[31:0];
		end
	endfunction

	// ln(1 + 2^-i) in unsigned q32
	function automatic logic [31:0] ln_q32(input int i);
		real    v;
		longint tmp;
		begin
			v   = $ln(1.0 + 2.0 ** (-i)) * 4294967296.0;
			tmp = longint'(v);
			return tmp[31:0];
		end
	endfunction

endpackage

// ----- hw/rtl/afu_exp_cell.sv -----
// ----------------------------------------------------------------------------
// afu_exp_cell
// One cell of the exponential chain: folds in the factor for one magnitude bit.
// ----------------------------------------------------------------------------
module afu_exp_cell #(
	parameter int          DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
	parameter int          BIT        = 0,
	parameter logic [31:0] C_SIG      = 32'd0,
	parameter logic [31:0] C_TANH     = 32'd0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  afu_pkg::ctrl_t        ctrl_i,
	input  logic [DATA_WIDTH-1:0] mag_i,
	input  logic [32:0]           t_i,
	output afu_pkg::ctrl_t        ctrl_o,
	output logic [DATA_WIDTH-1:0] mag_o,
	output logic [32:0]           t_o
);
	import afu_pkg::*;

	logic [31:0] coef;
	logic [64:0] prod;
	logic [32:0] t_next;
	ctrl_t       ctrl_q;
	logic [DATA_WIDTH-1:0] mag_q;
	logic [32:0] t_q;

	assign coef   = (ctrl_i.kind == KIND_TANH) ? C_TANH : C_SIG;
	assign prod   = t_i * {33'd0, coef};
	assign t_next = mag_i[BIT] ? prod[64:32] : t_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= mag_i;
			t_q   <= t_next;
		end
	end

	assign ctrl_o = ctrl_q;
	assign mag_o  = mag_q;
	assign t_o    = t_q;
endmodule

// ----- hw/rtl/afu_divlog_cell.sv -----
// ----------------------------------------------------------------------------
// afu_divlog_cell
// One cell of the reciprocal chain: one restoring division step for
// t/(1+t) and one shift-add normalization step for ln(1+t).
// ----------------------------------------------------------------------------
module afu_divlog_cell #(
	parameter int          DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
	parameter int          SHIFT      = 1,
	parameter logic [31:0] LN_C       = 32'd0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  afu_pkg::ctrl_t        ctrl_i,
	input  logic [DATA_WIDTH-1:0] mag_i,
	input  logic [32:0]           den_i,
	input  logic [33:0]           rem_i,
	input  logic [31:0]           quo_i,
	input  logic [32:0]           x_i,
	input  logic [31:0]           w_i,
	output afu_pkg::ctrl_t        ctrl_o,
	output logic [DATA_WIDTH-1:0] mag_o,
	output logic [32:0]           den_o,
	output logic [33:0]           rem_o,
	output logic [31:0]           quo_o,
	output logic [32:0]           x_o,
	output logic [31:0]           w_o
);
	import afu_pkg::*;

	logic [33:0] rem_sh;
	logic        ge;
	logic [33:0] cand;
	logic        take;
	ctrl_t       ctrl_q;
	logic [DATA_WIDTH-1:0] mag_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [31:0] quo_q;
	logic [32:0] x_q;
	logic [31:0] w_q;

	assign rem_sh = {rem_i[32:0], 1'b0};
	assign ge     = rem_sh >= {1'b0, den_i};
	assign cand   = {1'b0, x_i} + {1'b0, x_i >> SHIFT};
	assign take   = cand <= {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= mag_i;
			den_q <= den_i;
			rem_q <= ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
			quo_q <= {quo_i[30:0], ge};
			x_q   <= take ? cand[32:0] : x_i;
			w_q   <= take ? (w_i + LN_C) : w_i;
		end
	end

	assign ctrl_o = ctrl_q;
	assign mag_o  = mag_q;
	assign den_o  = den_q;
	assign rem_o  = rem_q;
	assign quo_o  = quo_q;
	assign x_o    = x_q;
	assign w_o    = w_q;
endmodule

// ----- hw/rtl/activation_function_unit.sv -----
// ----------------------------------------------------------------------------
// activation_function_unit
// Streaming activation unit: identity, binary step, sigmoid, tanh, relu and
// softplus or their derivatives on signed fixed-point samples.
//
//   channel     | valid           | stall           | payload
//   ------------+-----------------+-----------------+----------------
//   input       | sample_valid    | sample_stall    | sample
//   output      | activated_valid | activated_stall | activated
//   config      | cfg_we          | -               | cfg_index, cfg_wdata
//
// one beat per cycle unless the output stalls; the pipeline holds the exponent
// chain (one cell per magnitude bit) and the 32-cell division/log chain.
// reset clears config registers and all valid bits.
// a stalled output freezes the whole pipeline; bubbles pass through.
// ----------------------------------------------------------------------------
module activation_function_unit #(
	parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [afu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [afu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [DATA_WIDTH-1:0]        sample,
	output logic                                activated_valid,
	input  logic                                activated_stall,
	output logic signed [DATA_WIDTH-1:0]        activated
);
	import afu_pkg::*;

	localparam int RW = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 4;
	localparam logic signed [RW-1:0] ONE = RW'(1) <<< FRAC_BITS;
	localparam logic signed [RW-1:0] HI  = (RW'(1) <<< (DATA_WIDTH - 1)) - RW'(1);
	localparam logic signed [RW-1:0] LO  = -HI - RW'(1);
	localparam logic [34:0] RND = 35'd1 << (31 - FRAC_BITS);

	kind_t kind_q;
	logic  deriv_q;
	logic  en;

	ctrl_t                 ctrl_e [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] mag_e  [0:DATA_WIDTH];
	logic [32:0]           t_e    [0:DATA_WIDTH];

	ctrl_t                 ctrl_d [0:DIV_STEPS];
	logic [DATA_WIDTH-1:0] mag_d  [0:DIV_STEPS];
	logic [32:0]           den_d  [0:DIV_STEPS];
	logic [33:0]           rem_d  [0:DIV_STEPS];
	logic [31:0]           quo_d  [0:DIV_STEPS];
	logic [32:0]           x_d    [0:DIV_STEPS];
	logic [31:0]           w_d    [0:DIV_STEPS];

	ctrl_t                 ctrl_s0;
	logic [DATA_WIDTH-1:0] mag_s0;
	logic [31:0]           t_clip;
	ctrl_t                 ctrl_s1;
	logic [DATA_WIDTH-1:0] mag_s1;
	logic [31:0]           p_s1;
	logic [32:0]           q_s1;
	logic [31:0]           w_s1;
	logic [31:0]           pq_s1;
	logic [32:0]           q_next;
	logic [64:0]           pq_full;

	logic [34:0]           v_sel;
	logic                  frac_en;
	logic                  neg_res;
	logic signed [RW-1:0]  base;
	logic [34:0]           v_rnd;
	logic signed [RW-1:0]  frac;
	logic signed [RW-1:0]  sum;
	logic signed [RW-1:0]  res;
	logic signed [RW-1:0]  mag_x;
	logic signed [DATA_WIDTH-1:0] activated_q;
	logic                  out_valid_q;

	assign en           = !(out_valid_q && activated_stall);
	assign sample_stall = !en;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_IDENTITY;
			deriv_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVATION_KIND: kind_q  <= kind_t'(cfg_wdata);
				CFG_DERIVATIVE_MODE: deriv_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s0 <= '0;
		end else if (en) begin
			ctrl_s0.valid <= sample_valid;
			ctrl_s0.neg   <= sample[DATA_WIDTH-1];
			ctrl_s0.kind  <= kind_q;
			ctrl_s0.deriv <= deriv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s0 <= sample[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - sample) : sample;
		end
	end

	// exponent chain
	assign ctrl_e[0] = ctrl_s0;
	assign mag_e[0]  = mag_s0;
	assign t_e[0]    = 33'h1_0000_0000;

	for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_exp
		afu_exp_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.BIT        (g),
			.C_SIG      (exp_q32(g - FRAC_BITS)),
			.C_TANH     (exp_q32(g - FRAC_BITS + 1))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctrl_i (ctrl_e[g]),
			.mag_i  (mag_e[g]),
			.t_i    (t_e[g]),
			.ctrl_o (ctrl_e[g+1]),
			.mag_o  (mag_e[g+1]),
			.t_o    (t_e[g+1])
		);
	end

	assign t_clip = t_e[DATA_WIDTH][32] ? 32'hFFFF_FFFF : t_e[DATA_WIDTH][31:0];

	// division and log chain
	assign ctrl_d[0] = ctrl_e[DATA_WIDTH];
	assign mag_d[0]  = mag_e[DATA_WIDTH];
	assign den_d[0]  = {1'b1, t_clip};
	assign rem_d[0]  = {2'b00, t_clip};
	assign quo_d[0]  = 32'd0;
	assign x_d[0]    = 33'h1_0000_0000;
	assign w_d[0]    = 32'd0;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		afu_divlog_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.SHIFT      (g + 1),
			.LN_C       (ln_q32(g + 1))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctrl_i (ctrl_d[g]),
			.mag_i  (mag_d[g]),
			.den_i  (den_d[g]),
			.rem_i  (rem_d[g]),
			.quo_i  (quo_d[g]),
			.x_i    (x_d[g]),
			.w_i    (w_d[g]),
			.ctrl_o (ctrl_d[g+1]),
			.mag_o  (mag_d[g+1]),
			.den_o  (den_d[g+1]),
			.rem_o  (rem_d[g+1]),
			.quo_o  (quo_d[g+1]),
			.x_o    (x_d[g+1]),
			.w_o    (w_d[g+1])
		);
	end

	// derivative product stage
	assign q_next  = 33'h1_0000_0000 - {1'b0, quo_d[DIV_STEPS]};
	assign pq_full = {33'd0, quo_d[DIV_STEPS]} * {32'd0, q_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_d[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_d[DIV_STEPS];
			p_s1   <= quo_d[DIV_STEPS];
			q_s1   <= q_next;
			w_s1   <= w_d[DIV_STEPS];
			pq_s1  <= pq_full[63:32];
		end
	end

	// result select, rounding and saturation
	assign mag_x = signed'(RW'(mag_s1));

	always_comb begin
		v_sel   = '0;
		frac_en = 1'b0;
		neg_res = 1'b0;
		base    = '0;
		unique case (ctrl_s1.kind)
			KIND_IDENTITY: begin
				base = ctrl_s1.deriv ? ONE : (ctrl_s1.neg ? -mag_x : mag_x);
			end
			KIND_BINARY: begin
				base = (ctrl_s1.deriv || ctrl_s1.neg) ? '0 : ONE;
			end
			KIND_SIGMOID: begin
				frac_en = 1'b1;
				if (ctrl_s1.deriv) v_sel = {3'b000, pq_s1};
				else v_sel = ctrl_s1.neg ? {3'b000, p_s1} : {2'b00, q_s1};
			end
			KIND_TANH: begin
				frac_en = 1'b1;
				if (ctrl_s1.deriv) begin
					v_sel = {1'b0, pq_s1, 2'b00};
				end else begin
					v_sel   = {2'b00, q_s1 - {1'b0, p_s1}};
					neg_res = ctrl_s1.neg;
				end
			end
			KIND_RELU: begin
				if (ctrl_s1.neg) base = '0;
				else base = ctrl_s1.deriv ? ONE : mag_x;
			end
			KIND_SOFTPLUS: begin
				frac_en = 1'b1;
				if (ctrl_s1.deriv) begin
					v_sel = ctrl_s1.neg ? {3'b000, p_s1} : {2'b00, q_s1};
				end else begin
					v_sel = {3'b000, w_s1};
					base  = ctrl_s1.neg ? '0 : mag_x;
				end
			end
			default: ;
		endcase
	end

	assign v_rnd = v_sel + RND;
	assign frac  = frac_en ? signed'(RW'(v_rnd >> (32 - FRAC_BITS))) : '0;
	assign sum   = base + frac;
	assign res   = neg_res ? -sum : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (res > HI) activated_q <= HI[DATA_WIDTH-1:0];
			else if (res < LO) activated_q <= LO[DATA_WIDTH-1:0];
			else activated_q <= res[DATA_WIDTH-1:0];
		end
	end

	assign activated_valid = out_valid_q;
	assign activated       = activated_q;
endmodule

// ----- tb/activation_function_unit_checker.sv -----
// ----------------------------------------------------------------------------
// activation_function_unit_checker
// Watches the config port and both streaming channels of the activation
// unit. Every accepted sample beat gets a predicted result, computed in
// integer q32 arithmetic under the config in force when it was accepted.
// Every accepted result beat is compared against the oldest prediction.
// Sigmoid, tanh and softplus results may differ by up to 2 lsb; all
// other kinds must match exactly.
// ----------------------------------------------------------------------------
module activation_function_unit_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [afu_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [afu_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                                   sample_valid,
	input  logic                                   sample_stall,
	input  logic signed [15:0]                     sample,
	input  logic                                   activated_valid,
	input  logic                                   activated_stall,
	input  logic signed [15:0]                     activated,
	output int                                     errors,
	output int                                     pending,
	output int                                     beats_out
);
	import afu_pkg::*;

	localparam int DW = 16;
	localparam int FB = 12;
	localparam longint unsigned Q32_ONE = 64'd1 << 32;
	localparam longint unsigned Q32_LN2 = 64'd2977044472;

	typedef struct {
		logic signed [DW-1:0] value;
		bit                   loose;
	} act_expect_t;

	act_expect_t          act_expected[$];
	logic [2:0]           kind_reg;
	logic                 deriv_reg;

	function automatic longint unsigned exp_neg_q32(longint unsigned a);
		longint unsigned k, r, term, v;
		longint          sum;
		begin
			if (a >= (64'd32 << 32)) return 0;
			k = a / Q32_LN2;
			r = a - k * Q32_LN2;
			term = Q32_ONE;
			sum = longint'(Q32_ONE);
			for (int n = 1; n <= 16; n++) begin
				term = ((term * r) >> 32) / longint'(n);
				if (n % 2 == 1) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			if (k >= 63) return 0;
			v = longint'(unsigned'(sum)) >> k;
			if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
			return v;
		end
	endfunction

	function automatic longint unsigned log1p_q32(longint unsigned t);
		longint unsigned z, z2, p, sum;
		begin
			z = (t << 32) / (2 * Q32_ONE + t);
			z2 = (z * z) >> 32;
			p = z;
			sum = 0;
			for (int k = 0; k < 16; k++) begin
				sum += p / longint'(2 * k + 1);
				p = (p * z2) >> 32;
			end
			return 2 * sum;
		end
	endfunction

	function automatic longint round_q32(longint unsigned v);
		return longint'((v + (64'd1 << (31 - FB))) >> (32 - FB));
	endfunction

	function automatic act_expect_t predict_activation(logic [2:0] kind, logic deriv,
			logic [DW-1:0] w);
		act_expect_t     e;
		bit              neg;
		longint unsigned mag, a, t, p, q;
		longint          x, one, r;
		begin
			neg = w[DW-1];
			mag = neg ? ((64'd1 << DW) - w) : w;
			x = neg ? -longint'(mag) : longint'(mag);
			a = mag << (32 - FB);
			one = 64'sd1 << FB;
			r = 0;
			e.loose = 0;
			case (kind)
				KIND_IDENTITY: r = deriv ? one : x;
				KIND_BINARY: r = deriv ? 0 : (neg ? 0 : one);
				KIND_SIGMOID, KIND_SOFTPLUS: begin
					e.loose = 1;
					t = exp_neg_q32(a);
					p = (t << 32) / (Q32_ONE + t);
					q = Q32_ONE - p;
					if (kind == KIND_SIGMOID && deriv) r = round_q32((p * q) >> 32);
					else if (kind == KIND_SIGMOID || deriv) r = round_q32(neg ? p : q);
					else r = (neg ? 0 : longint'(mag)) + round_q32(log1p_q32(t));
				end
				KIND_TANH: begin
					e.loose = 1;
					t = exp_neg_q32(2 * a);
					p = (t << 32) / (Q32_ONE + t);
					q = Q32_ONE - p;
					if (deriv) r = round_q32(4 * ((p * q) >> 32));
					else begin
						r = round_q32(q - p);
						if (neg) r = -r;
					end
				end
				KIND_RELU: r = neg ? 0 : (deriv ? one : x);
				default: r = 0;
			endcase
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			e.value = r[DW-1:0];
			return e;
		end
	endfunction

	assign pending = act_expected.size();

	always @(posedge clk or negedge arst_n) begin
		act_expect_t e;
		int          diff;
		if (!arst_n) begin
			kind_reg <= '0;
			deriv_reg <= 1'b0;
			errors = 0;
			beats_out = 0;
			act_expected.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ACTIVATION_KIND) kind_reg <= cfg_wdata;
				else if (cfg_index == CFG_DERIVATIVE_MODE) deriv_reg <= cfg_wdata[0];
			end
			if (sample_valid && !sample_stall)
				act_expected.push_back(predict_activation(kind_reg, deriv_reg, sample));
			if (activated_valid && !activated_stall) begin
				beats_out++;
				if (act_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, actual %0d",
						$time, activated);
				end else begin
					e = act_expected.pop_front();
					diff = int'(activated) - int'(e.value);
					if (diff < 0) diff = -diff;
					if (e.loose ? diff > 2 : diff != 0) begin
						errors++;
						$display("%0t: activated mismatch, expected %0d, actual %0d",
							$time, e.value, activated);
					end
				end
			end
		end
	end

endmodule

// ----- tb/tb_activation_function_unit.sv -----
// ----------------------------------------------------------------------------
// tb_activation_function_unit
// Drives the activation unit through every kind, both derivative modes and
// the unused kind codes: directed edge samples, then random samples with
// random gaps and output stalls, one long output hold that backs the
// pipeline up into the input. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_activation_function_unit;
	import afu_pkg::*;

	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int LATENCY = 16 + 35;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  sample_valid;
	logic                  sample_stall;
	logic signed [15:0]    sample;
	logic                  activated_valid;
	logic                  activated_stall;
	logic signed [15:0]    activated;
	int                    errors;
	int                    pending;
	int                    beats_out;
	int                    beats_in;
	int                    idle_cycles;
	bit                    no_gaps;
	bit                    hold_req;
	bit                    held;

	activation_function_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.activated_valid(activated_valid), .activated_stall(activated_stall),
		.activated(activated)
	);

	activation_function_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.activated_valid(activated_valid), .activated_stall(activated_stall),
		.activated(activated),
		.errors(errors), .pending(pending), .beats_out(beats_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one input beat, with a random gap ahead of it
	task automatic send_sample(logic [15:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= val;
		do @(posedge clk); while (sample_stall);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	// receiver: random stall per beat, one long hold on request
	initial begin
		int n;
		activated_stall = 1'b1;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				activated_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1;
			end
			n = no_gaps ? 0 : $urandom_range(0, 7);
			if (n > 0) begin
				activated_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			activated_stall <= 1'b0;
			do @(posedge clk); while (!activated_valid);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (activated_valid && !activated_stall) || cfg_we)
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0]  kinds[8];
		logic [15:0] edges[$];
		int          phase;
		logic [15:0] v;
		kinds = '{KIND_IDENTITY, KIND_BINARY, KIND_SIGMOID, KIND_TANH,
			KIND_RELU, KIND_SOFTPLUS, KIND_SPARE_LO, KIND_SPARE_HI};
		edges = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h1000,
			16'hF000, 16'h0800, 16'hF800, 16'h2000, 16'hE000, 16'h5555, 16'hAAAA};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_valid = 1'b0;
		sample = '0;
		beats_in = 0;
		idle_cycles = 0;
		no_gaps = 0;
		hold_req = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// reset config first: identity value
		foreach (edges[i]) send_sample(edges[i]);
		drain();
		phase = 0;
		for (int d = 0; d < 2; d++) begin
			foreach (kinds[k]) begin
				write_reg(CFG_ACTIVATION_KIND, kinds[k]);
				write_reg(CFG_DERIVATIVE_MODE, CFG_DATA_W'(d));
				no_gaps = (phase % 5 == 3);
				if (phase == 6) hold_req = 1;
				foreach (edges[i]) send_sample(edges[i]);
				for (int n = 0; n < 65; n++) begin
					if ($urandom_range(0, 9) < 7) v = $urandom;
					else v = 16'($urandom_range(0, 16383)) - 16'd8192;
					send_sample(v);
				end
				drain();
				phase++;
			end
		end
		$display("covered %0d sample beats, %0d result beats over 8 kinds x 2 modes",
			beats_in, beats_out);
		$display("gaps, output stalls and one %0d-cycle output hold exercised",
			HOLD_CYCLES);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
